>>> rtl/core/cbz_pkg.sv
`default_nettype none

package cbz_pkg;

  localparam int NLANE  = 3;   // x, y, z
  localparam int NPT    = 4;   // control points
  localparam int NCELL  = 3;   // Horner steps of a cubic
  localparam int T_W    = 17;  // t in Q0.16, up to 1.0
  localparam int TFRAC  = 16;
  localparam int CRD_W  = 16;  // Q11.4 coordinate
  localparam int PT_W   = NLANE * CRD_W;
  localparam int C_W    = 20;  // power-basis coefficient
  localparam int ACC_W  = 54;  // running Horner value between cells
  localparam int LO_W   = 26;  // low split of the running value
  localparam int HI_W   = ACC_W - LO_W;
  localparam int SUM_W  = 64;  // exact Q11.52 sum
  localparam int FRAC_SH = 3 * TFRAC;
  localparam int CFG_AW = 3;

  typedef logic [T_W-1:0]          tpar_t;
  typedef logic [PT_W-1:0]         pt_t;
  typedef logic signed [C_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CFG_AW-1:0]       reg_idx_t;

  localparam tpar_t T_ONE = tpar_t'(1) << TFRAC;

  localparam reg_idx_t REG_POINT0 = 3'd0;
  localparam reg_idx_t REG_POINT1 = 3'd1;
  localparam reg_idx_t REG_POINT2 = 3'd2;
  localparam reg_idx_t REG_POINT3 = 3'd3;

  localparam pt_t PT_RESET [NPT] = '{
    48'd52491136, 48'd314636736, 48'd4116711776, 48'd41945280
  };

  function automatic coef_t crd_ext(input logic [CRD_W-1:0] c);
    return {{(C_W-CRD_W){c[CRD_W-1]}}, c};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cbz_coef.sv
`default_nettype none

// Bernstein control points -> power-basis coefficients, per lane:
// c0 = P0, c1 = 3(P1-P0), c2 = 3(P0-2P1+P2), c3 = P3-P0+3(P1-P2)
module cbz_coef import cbz_pkg::*; (
  input  pt_t   pts  [NPT],
  output coef_t coef [NPT][NLANE]
);

  coef_t p0 [NLANE];
  coef_t p1 [NLANE];
  coef_t p2 [NLANE];
  coef_t p3 [NLANE];
  coef_t d1 [NLANE];
  coef_t d2 [NLANE];
  coef_t d3 [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      p0[l] = crd_ext(pts[0][l*CRD_W +: CRD_W]);
      p1[l] = crd_ext(pts[1][l*CRD_W +: CRD_W]);
      p2[l] = crd_ext(pts[2][l*CRD_W +: CRD_W]);
      p3[l] = crd_ext(pts[3][l*CRD_W +: CRD_W]);
      d1[l] = p1[l] - p0[l];
      d2[l] = p0[l] - (p1[l] <<< 1) + p2[l];
      d3[l] = p1[l] - p2[l];
      coef[0][l] = p0[l];
      coef[1][l] = (d1[l] <<< 1) + d1[l];
      coef[2][l] = (d2[l] <<< 1) + d2[l];
      coef[3][l] = p3[l] - p0[l] + (d3[l] <<< 1) + d3[l];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cbz_cell.sv
`default_nettype none

// One Horner step for all lanes: sum = acc * t + term.
// Stage A forms two partial products of acc * t, stage B adds them and term.
module cbz_cell import cbz_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  tpar_t in_t,
  input  acc_t  in_acc [NLANE],
  input  sum_t  term   [NLANE],
  output logic  out_valid,
  input  logic  out_ready,
  output tpar_t out_t,
  output sum_t  out_sum [NLANE]
);

  localparam int HP_W = HI_W + T_W;
  localparam int LP_W = LO_W + T_W;

  logic va_r, va_nxt;
  logic vb_r, vb_nxt;
  logic rdy_a, rdy_b;

  tpar_t ta_r, tb_r;
  logic signed [HP_W-1:0] hi_r   [NLANE];
  logic signed [HP_W-1:0] hi_nxt [NLANE];
  logic [LP_W-1:0]        lo_r   [NLANE];
  logic [LP_W-1:0]        lo_nxt [NLANE];
  sum_t                   sum_r  [NLANE];
  sum_t                   sum_nxt[NLANE];

  always_comb begin
    rdy_b  = !vb_r || out_ready;
    rdy_a  = !va_r || rdy_b;
    va_nxt = rdy_a ? in_valid : va_r;
    vb_nxt = rdy_b ? va_r : vb_r;
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      hi_nxt[l]  = $signed(in_acc[l][ACC_W-1:LO_W]) * $signed({1'b0, in_t});
      lo_nxt[l]  = in_acc[l][LO_W-1:0] * in_t;
      sum_nxt[l] = ({{(SUM_W-HP_W){hi_r[l][HP_W-1]}}, hi_r[l]} <<< LO_W)
                 + {{(SUM_W-LP_W){1'b0}}, lo_r[l]} + term[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      ta_r <= in_t;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    if (va_r && rdy_b) begin
      tb_r  <= ta_r;
      sum_r <= sum_nxt;
    end
  end

  assign in_ready  = rdy_a;
  assign out_valid = vb_r;
  assign out_t     = tb_r;
  assign out_sum   = sum_r;

endmodule

`default_nettype wire

>>> rtl/core/cubic_bezier_point_eval_unit.sv
`default_nettype none

// channel | dir | payload
// --------+-----+--------------------------------------------------------
// in_     | in  | tdata[16:0] t_param (Q0.16, above 1.0 clamps to 1.0)
// out_    | out | tdata x[15:0] y[31:16] z[47:32], signed Q11.4
// cfg_    | in  | addr = point index 0..3, data = packed x/y/z point
//
// One request per cycle sustained while out_tready does not hold the flow; each
// request passes three Horner cells of two stages each, then the rounding register.
// Every stage holds its own valid flag, so bubbles close up under a stall and
// requests keep entering while a result waits on out_tready, until every stage is full.
// Reset clears the valid flags and loads the four default control points.
module cubic_bezier_point_eval_unit import cbz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // t_param[16:0], zero pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PT_W-1:0]      out_tdata,  // point_x, point_y, point_z
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [PT_W-1:0]      cfg_data
);

  pt_t   pt_r   [NPT];
  pt_t   pt_nxt [NPT];
  coef_t coef   [NPT][NLANE];

  tpar_t t_sat;

  logic  cv [NCELL+1];
  logic  cr [NCELL+1];
  tpar_t ct [NCELL];
  acc_t  ca [NCELL][NLANE];
  sum_t  cterm [NCELL][NLANE];
  sum_t  cs [NCELL][NLANE];

  logic             o_valid_r, o_valid_nxt;
  logic [PT_W-1:0]  o_data_r, o_data_nxt;
  sum_t             rnd [NLANE];

  localparam sum_t HALF = sum_t'(1) <<< (FRAC_SH - 1);

  // configuration
  always_comb begin
    pt_nxt = pt_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        REG_POINT0: pt_nxt[0] = cfg_data;
        REG_POINT1: pt_nxt[1] = cfg_data;
        REG_POINT2: pt_nxt[2] = cfg_data;
        REG_POINT3: pt_nxt[3] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= PT_RESET;
    end else begin
      pt_r <= pt_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  cbz_coef u_coef (
    .pts  (pt_r),
    .coef (coef)
  );

  assign t_sat     = (in_tdata[T_W-1:0] > T_ONE) ? T_ONE : in_tdata[T_W-1:0];
  assign cv[0]     = in_tvalid;
  assign in_tready = cr[0];
  assign ct[0]     = t_sat;

  // cell g adds c(2-g) scaled by 2^(16(g+1)); the first cell starts from c3
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    localparam int SH = TFRAC * (g + 1);
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      assign cterm[g][l] =
        {{(SUM_W-C_W){coef[NCELL-1-g][l][C_W-1]}}, coef[NCELL-1-g][l]} <<< SH;
      if (g == 0) begin : g_first
        assign ca[g][l] = {{(ACC_W-C_W){coef[NCELL][l][C_W-1]}}, coef[NCELL][l]};
      end else begin : g_next
        assign ca[g][l] = cs[g-1][l][ACC_W-1:0];
      end
    end

    if (g < NCELL - 1) begin : g_mid
      cbz_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[g]),
        .in_ready  (cr[g]),
        .in_t      (ct[g]),
        .in_acc    (ca[g]),
        .term      (cterm[g]),
        .out_valid (cv[g+1]),
        .out_ready (cr[g+1]),
        .out_t     (ct[g+1]),
        .out_sum   (cs[g])
      );
    end else begin : g_last
      cbz_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[g]),
        .in_ready  (cr[g]),
        .in_t      (ct[g]),
        .in_acc    (ca[g]),
        .term      (cterm[g]),
        .out_valid (cv[g+1]),
        .out_ready (cr[g+1]),
        .out_t     (),
        .out_sum   (cs[g])
      );
    end
  end

  assign cr[NCELL] = !o_valid_r || out_tready;

  // round to nearest, ties up, then drop the 48 fraction bits
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      rnd[l] = cs[NCELL-1][l] + HALF;
      o_data_nxt[l*CRD_W +: CRD_W] = rnd[l][SUM_W-1:FRAC_SH];
    end
    o_valid_nxt = cr[NCELL] ? cv[NCELL] : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cv[NCELL] && cr[NCELL]) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
  import cbz_pkg::*;

  localparam int PIPE_LAT = 7;
  localparam int CHUNK    = 103;
  localparam int HOLD_CYC = 80;
  localparam int SEND_IDLE [3] = '{12, 54, 0};
  localparam int RECV_IDLE [3] = '{54, 12, 0};

  localparam reg_idx_t PT_IDX [NPT] = '{REG_POINT0, REG_POINT1, REG_POINT2, REG_POINT3};
  localparam reg_idx_t IDX_TOP = '1;  // 4..IDX_TOP decode to nothing

  localparam pt_t PT_MAX  = {NLANE{16'h7fff}};
  localparam pt_t PT_MIN  = {NLANE{16'h8000}};
  localparam pt_t PT_ZERO = '0;
  // x = 0.25, y = -0.25, z = 0.75 in Q11.4: exact halves at t = 0.5
  localparam pt_t PT_HALF = {16'h000c, 16'hfffc, 16'h0004};

  typedef struct packed {
    logic signed [CRD_W-1:0] pz;
    logic signed [CRD_W-1:0] py;
    logic signed [CRD_W-1:0] px;
  } xyz_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid, in_tready;
  logic [23:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [PT_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  reg_idx_t cfg_addr;
  pt_t cfg_data;

  tpar_t t_pending [$];
  xyz_t point_due [$];
  pt_t ctrl_pts [NPT];
  logic in_hs = 1'b0;
  logic recv_hold = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fault_cnt = 0;

  cubic_bezier_point_eval_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bernstein weights are exact Q0.48; the 64-bit sum wraps like the hardware
  function automatic xyz_t bezier_point(input tpar_t t_in);
    longint t, u, acc;
    longint w [NPT];
    logic signed [CRD_W-1:0] crd;
    logic [63:0] sum;
    logic [PT_W-1:0] res;
    t = (t_in > T_ONE) ? longint'(T_ONE) : longint'(t_in);
    u = longint'(T_ONE) - t;
    w[0] = u * u * u;
    w[1] = 3 * t * u * u;
    w[2] = 3 * t * t * u;
    w[3] = t * t * t;
    for (int lane = 0; lane < NLANE; lane++) begin
      acc = longint'(1) << 47;
      for (int k = 0; k < NPT; k++) begin
        crd = ctrl_pts[k][lane*CRD_W +: CRD_W];
        acc += w[k] * longint'(crd);
      end
      sum = acc;
      res[lane*CRD_W +: CRD_W] = sum[63:48];
    end
    return xyz_t'(res);
  endfunction

  task automatic note_fault(input string what, input int got, input int want);
    if (fault_cnt < 50)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fault_cnt++;
  endtask

  function automatic tpar_t rand_t();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80)
      return tpar_t'($urandom_range(32'(T_ONE)));
    if (r < 90)
      return tpar_t'($urandom_range(131071, 32'(T_ONE) + 1));  // clamps to 1.0
    case ($urandom_range(3))
      0: return '0;
      1: return T_ONE;
      2: return tpar_t'(1);
      default: return '1;
    endcase
  endfunction

  function automatic pt_t rand_point();
    pt_t p;
    for (int lane = 0; lane < NLANE; lane++) begin
      case ($urandom_range(9))
        0: p[lane*CRD_W +: CRD_W] = 16'h7fff;
        1: p[lane*CRD_W +: CRD_W] = 16'h8000;
        default: p[lane*CRD_W +: CRD_W] = 16'($urandom_range(65535));
      endcase
    end
    return p;
  endfunction

  // driver: stimulus and receiver backpressure change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_hs) begin
        if (t_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= 24'(t_pending.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: config shadow, prediction on accept, in-order compare
  always @(posedge clk) begin
    xyz_t got, want;
    in_hs = in_tvalid && in_tready;
    if (rst_n && cfg_valid && cfg_ready && cfg_addr <= REG_POINT3)
      ctrl_pts[cfg_addr[1:0]] = cfg_data;
    if (rst_n && in_hs)
      point_due.push_back(bezier_point(tpar_t'(in_tdata)));
    if (rst_n && out_tvalid && out_tready) begin
      got = xyz_t'(out_tdata);
      if (point_due.size() == 0) begin
        note_fault("unexpected result, x", int'(got.px), 0);
      end else begin
        want = point_due.pop_front();
        if (got.px !== want.px) note_fault("point_x", int'(got.px), int'(want.px));
        if (got.py !== want.py) note_fault("point_y", int'(got.py), int'(want.py));
        if (got.pz !== want.pz) note_fault("point_z", int'(got.pz), int'(want.pz));
      end
    end
  end

  task automatic write_point(input reg_idx_t idx, input pt_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_points(input pt_t p0, input pt_t p1, input pt_t p2, input pt_t p3);
    write_point(PT_IDX[0], p0);
    write_point(PT_IDX[1], p1);
    write_point(PT_IDX[2], p2);
    write_point(PT_IDX[3], p3);
  endtask

  task automatic wait_idle();
    while (t_pending.size() != 0 || in_tvalid || point_due.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);
  endtask

  task automatic load_rand_points();
    set_points(rand_point(), rand_point(), rand_point(), rand_point());
    // writes to undecoded indexes must leave the points alone
    if ($urandom_range(1))
      write_point(reg_idx_t'($urandom_range(IDX_TOP, REG_POINT3 + 1)), rand_point());
  endtask

  initial begin
    int waited;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = REG_POINT0;
    cfg_data = '0;
    foreach (ctrl_pts[i]) ctrl_pts[i] = PT_RESET[i];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];

    // default points straight out of reset, including clamped parameters
    t_pending = '{tpar_t'(0), T_ONE, tpar_t'(1), tpar_t'(65535), tpar_t'(32768),
                  tpar_t'(65537), tpar_t'(131071), tpar_t'(98304)};
    wait_idle();

    set_points(PT_MAX, PT_MAX, PT_MAX, PT_MAX);
    t_pending = '{tpar_t'(0), tpar_t'(21845), T_ONE};
    wait_idle();

    set_points(PT_MIN, PT_MIN, PT_MIN, PT_MIN);
    write_point(IDX_TOP, PT_MAX);
    t_pending = '{tpar_t'(0), tpar_t'(43691), T_ONE};
    wait_idle();

    set_points(PT_MAX, PT_MIN, PT_MAX, PT_MIN);
    t_pending = '{tpar_t'(16384), tpar_t'(49152), tpar_t'(32768)};
    wait_idle();

    // exact half LSB: rounds up on both signs
    set_points(PT_HALF, PT_ZERO, PT_ZERO, PT_ZERO);
    t_pending = '{tpar_t'(32768)};
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_idle_pct = RECV_IDLE[ph];
      for (int ck = 0; ck < 4; ck++) begin
        if (ck % 2 == 0)
          load_rand_points();
        if (ck == 1 && ph != 1) begin
          // long receiver stall while the sender keeps pushing
          fork
            begin
              recv_hold = 1'b1;
              repeat (HOLD_CYC) @(posedge clk);
              recv_hold = 1'b0;
            end
          join_none
        end
        repeat (CHUNK) t_pending.push_back(rand_t());
        wait_idle();
      end
    end

    waited = 0;
    while ((t_pending.size() != 0 || in_tvalid || point_due.size() != 0) && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (point_due.size() != 0)
      note_fault("results never arrived", 0, point_due.size());

    if (fault_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
